### design/rie_pkg.sv
`timescale 1ns / 1ps
// Shared types, kind codes, opcodes and format packing functions for the
// RISC-V instruction encoder. No dependencies.
package rie_pkg;

   // operation kinds
   localparam logic [4:0] KIND_ADD   = 5'd0;
   localparam logic [4:0] KIND_ADDI  = 5'd1;
   localparam logic [4:0] KIND_ADDIW = 5'd2;
   localparam logic [4:0] KIND_MUL   = 5'd3;
   localparam logic [4:0] KIND_BEQ   = 5'd4;
   localparam logic [4:0] KIND_BNE   = 5'd5;
   localparam logic [4:0] KIND_BGE   = 5'd6;
   localparam logic [4:0] KIND_BLT   = 5'd7;
   localparam logic [4:0] KIND_BNEZ  = 5'd8;
   localparam logic [4:0] KIND_JAL   = 5'd9;
   localparam logic [4:0] KIND_JALR  = 5'd10;
   localparam logic [4:0] KIND_RET   = 5'd11;
   localparam logic [4:0] KIND_LB    = 5'd12;
   localparam logic [4:0] KIND_LH    = 5'd13;
   localparam logic [4:0] KIND_LW    = 5'd14;
   localparam logic [4:0] KIND_LD    = 5'd15;
   localparam logic [4:0] KIND_SB    = 5'd16;
   localparam logic [4:0] KIND_SH    = 5'd17;
   localparam logic [4:0] KIND_SW    = 5'd18;
   localparam logic [4:0] KIND_SD    = 5'd19;
   localparam logic [4:0] KIND_LUI   = 5'd20;
   localparam logic [4:0] KIND_AUIPC = 5'd21;
   localparam logic [4:0] KIND_SRLI  = 5'd22;
   localparam logic [4:0] KIND_SLLI  = 5'd23;
   localparam logic [4:0] KIND_J     = 5'd24;
   localparam logic [4:0] KIND_CALL  = 5'd25;
   localparam logic [4:0] KIND_RAW   = 5'd26;

   // major opcodes
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_IMM32  = 7'b0011011;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] F7_MULDIV = 7'b0000001;
   localparam logic [6:0] F7_ZERO   = 7'b0000000;

   localparam logic [2:0] F3_0 = 3'd0;
   localparam logic [2:0] F3_1 = 3'd1;
   localparam logic [2:0] F3_2 = 3'd2;
   localparam logic [2:0] F3_3 = 3'd3;
   localparam logic [2:0] F3_4 = 3'd4;
   localparam logic [2:0] F3_5 = 3'd5;

   localparam logic [4:0] REG_ZERO = 5'd0;
   localparam logic [4:0] REG_RA   = 5'd1;
   localparam logic [4:0] REG_T0   = 5'd5;
   localparam logic [4:0] REG_T1   = 5'd6;

   typedef struct packed {
      logic [4:0]         kind;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [31:0] immediate;
      logic [31:0]        raw_word;
   } req_type;

   // encoder result: one or two words
   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic        pair;
      logic        unknown;
   } enc_type;

   function automatic logic [31:0] fmt_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
      return {f7, rs2, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] fmt_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                         logic [4:0] rd, logic [6:0] op);
      return {imm, rs1, f3, rd, op};
   endfunction

   function automatic logic [31:0] fmt_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [6:0] op);
      return {imm[11:5], rs2, rs1, f3, imm[4:0], op};
   endfunction

   function automatic logic [31:0] fmt_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                         logic [2:0] f3, logic [6:0] op);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], op};
   endfunction

   function automatic logic [31:0] fmt_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
      return {imm, rd, op};
   endfunction

   function automatic logic [31:0] fmt_j(logic [20:0] imm, logic [4:0] rd, logic [6:0] op);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, op};
   endfunction

endpackage

### design/rie_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready plus the operation fields of one item.
// Depends on nothing.
interface rie_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         kind;
   logic [4:0]         dest_reg;
   logic [4:0]         src1_reg;
   logic [4:0]         src2_reg;
   logic signed [31:0] immediate;
   logic [31:0]        raw_word;

   modport source (output valid, kind, dest_reg, src1_reg, src2_reg, immediate, raw_word,
                   input ready);
   modport sink (input valid, kind, dest_reg, src1_reg, src2_reg, immediate, raw_word,
                 output ready);
endinterface

### design/rie_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready plus one encoded machine word and flags.
// Depends on nothing.
interface rie_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;
   logic        last;
   logic        unknown_kind;

   modport source (output valid, instruction_word, last, unknown_kind, input ready);
   modport sink (input valid, instruction_word, last, unknown_kind, output ready);
endinterface

### design/rie_encode.sv
`timescale 1ns / 1ps
// Combinational packer: turns one registered request into one or two words.
// Depends on rie_pkg.
module rie_encode (
   input  rie_pkg::req_type req_item,
   output rie_pkg::enc_type enc
);
   import rie_pkg::*;

   logic [31:0] imm;
   logic [31:0] far_off;
   logic [19:0] far_hi;
   logic [4:0]  far_tmp;
   logic [4:0]  far_link;

   assign imm = req_item.immediate;

   always_comb begin
      far_off  = (req_item.kind == KIND_J) ? {imm[29:0], 2'b00} : imm;
      far_tmp  = (req_item.kind == KIND_J) ? REG_T0 : REG_T1;
      far_link = (req_item.kind == KIND_J) ? REG_ZERO : REG_RA;
      // round the upper part so the sign-extended low part adds back exactly
      far_hi   = far_off[31:12] + {19'd0, far_off[11]};
   end

   always_comb begin
      enc.word0   = '0;
      enc.word1   = fmt_i(far_off[11:0], far_tmp, F3_0, far_link, OP_JALR);
      enc.pair    = 1'b0;
      enc.unknown = 1'b0;
      unique case (req_item.kind) inside
         KIND_ADD:   enc.word0 = fmt_r(F7_ZERO, req_item.src2_reg, req_item.src1_reg, F3_0,
                                       req_item.dest_reg, OP_REG);
         KIND_ADDI:  enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_0, req_item.dest_reg,
                                       OP_IMM);
         KIND_ADDIW: enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_0, req_item.dest_reg,
                                       OP_IMM32);
         KIND_MUL:   enc.word0 = fmt_r(F7_MULDIV, req_item.src2_reg, req_item.src1_reg, F3_0,
                                       req_item.dest_reg, OP_REG);
         KIND_BEQ:   enc.word0 = fmt_b(imm[12:0], req_item.src2_reg, req_item.src1_reg, F3_0,
                                       OP_BRANCH);
         KIND_BNE:   enc.word0 = fmt_b(imm[12:0], req_item.src2_reg, req_item.src1_reg, F3_1,
                                       OP_BRANCH);
         KIND_BGE:   enc.word0 = fmt_b(imm[12:0], req_item.src2_reg, req_item.src1_reg, F3_5,
                                       OP_BRANCH);
         KIND_BLT:   enc.word0 = fmt_b(imm[12:0], req_item.src2_reg, req_item.src1_reg, F3_4,
                                       OP_BRANCH);
         KIND_BNEZ:  enc.word0 = fmt_b(imm[12:0], REG_ZERO, req_item.dest_reg, F3_1, OP_BRANCH);
         KIND_JAL:   enc.word0 = fmt_j(imm[20:0], req_item.dest_reg, OP_JAL);
         KIND_JALR:  enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_0, req_item.dest_reg,
                                       OP_JALR);
         KIND_RET:   enc.word0 = fmt_i(12'd0, REG_RA, F3_0, REG_ZERO, OP_JALR);
         KIND_LB:    enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_0, req_item.dest_reg,
                                       OP_LOAD);
         KIND_LH:    enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_1, req_item.dest_reg,
                                       OP_LOAD);
         KIND_LW:    enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_2, req_item.dest_reg,
                                       OP_LOAD);
         KIND_LD:    enc.word0 = fmt_i(imm[11:0], req_item.src1_reg, F3_3, req_item.dest_reg,
                                       OP_LOAD);
         KIND_SB:    enc.word0 = fmt_s(imm[11:0], req_item.src2_reg, req_item.src1_reg, F3_0,
                                       OP_STORE);
         KIND_SH:    enc.word0 = fmt_s(imm[11:0], req_item.src2_reg, req_item.src1_reg, F3_1,
                                       OP_STORE);
         KIND_SW:    enc.word0 = fmt_s(imm[11:0], req_item.src2_reg, req_item.src1_reg, F3_2,
                                       OP_STORE);
         KIND_SD:    enc.word0 = fmt_s(imm[11:0], req_item.src2_reg, req_item.src1_reg, F3_3,
                                       OP_STORE);
         KIND_LUI:   enc.word0 = fmt_u(imm[19:0], req_item.dest_reg, OP_LUI);
         KIND_AUIPC: enc.word0 = fmt_u(imm[19:0], req_item.dest_reg, OP_AUIPC);
         KIND_SRLI:  enc.word0 = fmt_i({6'd0, imm[5:0]}, req_item.src1_reg, F3_5,
                                       req_item.dest_reg, OP_IMM);
         KIND_SLLI:  enc.word0 = fmt_i({6'd0, imm[5:0]}, req_item.src1_reg, F3_1,
                                       req_item.dest_reg, OP_IMM);
         KIND_J, KIND_CALL: begin
            enc.word0 = fmt_u(far_hi, far_tmp, OP_AUIPC);
            enc.pair  = 1'b1;
         end
         KIND_RAW:   enc.word0 = req_item.raw_word;
         default:    enc.unknown = 1'b1;
      endcase
   end

endmodule

### design/rie_out.sv
`timescale 1ns / 1ps
// Result register: holds one encoded item and sends its one or two words.
// Depends on rie_pkg and rie_rsp_if.
module rie_out (
   input  logic             clock,
   input  logic             reset,
   input  logic             load_valid,
   input  rie_pkg::enc_type enc,
   output logic             load_ready,
   rie_rsp_if.source        rsp_bus
);
   import rie_pkg::*;

   logic    valid_ff, valid_in;
   logic    second_ff, second_in;
   enc_type item_ff;
   logic    last_word;
   logic    fire;

   assign last_word  = !item_ff.pair || second_ff;
   assign fire       = valid_ff && rsp_bus.ready;
   assign load_ready = !valid_ff || (fire && last_word);

   always_comb begin
      valid_in  = valid_ff;
      second_in = second_ff;
      if (fire && !last_word) begin
         second_in = 1'b1;
      end
      if (load_ready) begin
         valid_in  = load_valid;
         second_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ready && load_valid) begin
         item_ff <= enc;
      end
   end

   assign rsp_bus.valid            = valid_ff;
   assign rsp_bus.instruction_word = second_ff ? item_ff.word1 : item_ff.word0;
   assign rsp_bus.last             = last_word;
   assign rsp_bus.unknown_kind     = item_ff.unknown;

endmodule

### design/riscv_instruction_encoder_top.sv
// First word of an item passes the input register, then the result register behind
// packing, before it can be taken.
// Throughput: one item per cycle while the response side is ready; j and call give two
// words and hold the result register for both, so those items hold back the next item.
// Reset (synchronous, active high) empties both registers and the second-word flag.
`timescale 1ns / 1ps
module riscv_instruction_encoder_top (
   input logic     clock,
   input logic     reset,
   rie_req_if.sink   req_bus,
   rie_rsp_if.source rsp_bus
);
   import rie_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   req_type req_item;
   enc_type enc;
   logic    out_ready;

   assign req_item = '{kind:      req_bus.kind,
                       dest_reg:  req_bus.dest_reg,
                       src1_reg:  req_bus.src1_reg,
                       src2_reg:  req_bus.src2_reg,
                       immediate: req_bus.immediate,
                       raw_word:  req_bus.raw_word};

   assign req_bus.ready = !in_valid_ff || out_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) begin
         in_valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_item_ff <= req_item;
      end
   end

   rie_encode u_encode (
      .req_item (in_item_ff),
      .enc      (enc)
   );

   rie_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .enc        (enc),
      .load_ready (out_ready),
      .rsp_bus    (rsp_bus)
   );

`ifndef ASSERT_OFF
   // the first word of a pair is always followed at once by its closing word
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last |=> rsp_bus.valid && rsp_bus.last)
      else $error("second word of a pair missing");

   // a flagged kind never expands and carries a zero word
   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.unknown_kind |-> rsp_bus.last && rsp_bus.instruction_word == 0)
      else $error("unknown kind result malformed");

   // an item waiting in the input register is never dropped while output stalls
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("input register lost an item");

   assert property (@(posedge clock) reset |=> !rsp_bus.valid && !in_valid_ff)
      else $error("registers not empty after reset");
`endif

endmodule
